@@ rtl/first_fit_heap_allocator_top_macros.svh @@
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Shared property wrappers clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFHA_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffha check failed");

// next-cycle implication
`define FFHA_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffha check failed");

`endif

@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, constants and codes shared by the heap allocator cells and control.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int C_MAX_BLOCKS   = 256;
    localparam int C_HEAP_LIMIT   = 67108864;
    localparam int C_PAGE_BYTES   = 4096;
    localparam int C_INIT_BYTES   = 16384;

    localparam int HDR_BYTES = 32;
    localparam int FTR_BYTES = 8;
    localparam int OVH_BYTES = HDR_BYTES + FTR_BYTES;
    localparam int SPLIT_MIN = OVH_BYTES + 8;

    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_OOM       = 3'd2,
        ST_NULL      = 3'd3,
        ST_NOT_START = 3'd4,
        ST_DOUBLE    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        TK_ALLOC = 2'd0,
        TK_FREE  = 2'd1,
        TK_GROW  = 2'd2
    } t_tkop;

    typedef enum logic [2:0] {
        MD_SRCH = 3'd0,
        MD_INS  = 3'd1,
        MD_MCHK = 3'd2,
        MD_DEL  = 3'd3,
        MD_EXT  = 3'd4,
        MD_APP  = 3'd5,
        MD_DONE = 3'd6
    } t_md;

    typedef struct packed {
        logic        v;
        logic [25:0] start;
        logic [25:0] size;
        logic        free;
    } t_ent;

    typedef struct packed {
        logic        act;
        t_tkop       op;
        t_md         md;
        logic [27:0] want;
        logic [25:0] off;
        logic        sok;
        logic        hit;
        logic        dbl;
        logic        spl;
        logic        mrg;
        logic [25:0] pay;
        t_ent        cry;
        t_ent        lst;
    } t_tok;

    typedef struct packed {
        logic ld;
        logic mrg;
        t_ent ent;
    } t_back;

endpackage

@@ rtl/ffha_cell.sv @@
// ----------------------------------------------------------------------------
// ffha_cell
// One heap block table entry; acts on the token word passing through it.
// ----------------------------------------------------------------------------
module ffha_cell #(
    parameter logic        P_FIRST = 1'b0,
    parameter logic [25:0] P_SIZE  = '0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffha_pkg::t_tok  i_tok,
    input  ffha_pkg::t_back i_back,
    output ffha_pkg::t_tok  o_tok,
    output ffha_pkg::t_back o_back
);
    import ffha_pkg::*;

    t_ent r_ent, n_ent;
    t_tok r_tok, n_tok;

    always_comb begin
        n_ent  = r_ent;
        n_tok  = i_tok;
        o_back = '0;
        if (i_back.ld) begin
            if (i_back.mrg) begin
                n_ent.size = r_ent.size + 26'(OVH_BYTES) + i_back.ent.size;
            end else begin
                n_ent = i_back.ent;
            end
        end
        if (i_tok.act) begin
            case (i_tok.md)
                MD_SRCH: begin
                    if (i_tok.op == TK_FREE) begin
                        if (r_ent.v && ({1'b0, r_ent.start} + 27'(HDR_BYTES))
                                == {1'b0, i_tok.off}) begin
                            n_tok.hit = 1'b1;
                            if (r_ent.free) begin
                                n_tok.dbl = 1'b1;
                                n_tok.md  = MD_DONE;
                            end else begin
                                n_ent.free = 1'b1;
                                n_tok.md   = MD_MCHK;
                            end
                        end
                    end else if (r_ent.v && r_ent.free
                            && {2'b0, r_ent.size} >= i_tok.want) begin
                        n_tok.hit  = 1'b1;
                        n_tok.pay  = r_ent.start + 26'(HDR_BYTES);
                        n_ent.free = 1'b0;
                        n_tok.md   = MD_DONE;
                        if (i_tok.sok
                                && {2'b0, r_ent.size} >= i_tok.want + 28'(SPLIT_MIN)) begin
                            n_ent.size      = i_tok.want[25:0];
                            n_tok.cry.v     = 1'b1;
                            n_tok.cry.start = r_ent.start + 26'(OVH_BYTES)
                                              + i_tok.want[25:0];
                            n_tok.cry.size  = r_ent.size - i_tok.want[25:0]
                                              - 26'(OVH_BYTES);
                            n_tok.cry.free  = 1'b1;
                            n_tok.md        = MD_INS;
                            n_tok.spl       = 1'b1;
                        end
                    end
                end
                MD_INS: begin
                    n_ent     = i_tok.cry;
                    n_tok.cry = r_ent;
                end
                MD_MCHK: begin
                    if (r_ent.v && r_ent.free) begin
                        o_back.ld  = 1'b1;
                        o_back.mrg = 1'b1;
                        o_back.ent = r_ent;
                        n_ent.v    = 1'b0;
                        n_tok.md   = MD_DEL;
                        n_tok.mrg  = 1'b1;
                    end else begin
                        n_tok.md = MD_DONE;
                    end
                end
                MD_DEL: begin
                    o_back.ld  = 1'b1;
                    o_back.ent = r_ent;
                    n_ent.v    = 1'b0;
                end
                MD_EXT: begin
                    if (r_ent.v && r_ent.start == i_tok.cry.start) begin
                        n_ent.size = i_tok.cry.size;
                        n_tok.md   = MD_DONE;
                    end
                end
                MD_APP: begin
                    if (!r_ent.v) begin
                        n_ent    = i_tok.cry;
                        n_tok.md = MD_DONE;
                    end
                end
                default: begin
                end
            endcase
            if (n_ent.v) begin
                n_tok.lst = n_ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.v     <= P_FIRST;
            r_ent.start <= '0;
            r_ent.size  <= P_SIZE;
            r_ent.free  <= P_FIRST;
            r_tok       <= '0;
        end else begin
            r_ent <= n_ent;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Command sequencer: launches token words, grows the heap, forms results.
// ----------------------------------------------------------------------------
module ffha_ctrl #(
    parameter int MAX_BLOCKS       = ffha_pkg::C_MAX_BLOCKS,
    parameter int HEAP_LIMIT_BYTES = ffha_pkg::C_HEAP_LIMIT,
    parameter int PAGE_BYTES       = ffha_pkg::C_PAGE_BYTES,
    parameter int INITIAL_BYTES    = ffha_pkg::C_INIT_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_opcode,
    input  logic [26:0]    i_request_size,
    input  logic [25:0]    i_block_offset,
    output ffha_pkg::t_tok o_tok,
    input  ffha_pkg::t_tok i_tok,
    output logic           o_valid,
    output logic [25:0]    o_payload_offset,
    output logic [2:0]     o_status,
    output logic [31:0]    o_corruption_total
);
    import ffha_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_RUN  = 5'b00100,
        S_G1   = 5'b01000,
        S_G2   = 5'b10000
    } t_state;

    t_state      r_st, n_st;
    logic        r_op, n_op;
    logic [26:0] r_size, n_size;
    logic [25:0] r_off, n_off;
    logic [27:0] r_want, n_want;
    logic        r_grown, n_grown;
    logic [CW-1:0] r_count, n_count;
    logic [26:0] r_mapped, n_mapped;
    logic [26:0] r_end, n_end;
    logic [31:0] r_bad, n_bad;
    t_ent        r_lst, n_lst;
    t_tok        r_ltok, n_ltok;
    logic        r_vld, n_vld;
    logic [25:0] r_pay, n_pay;
    t_status     r_res, n_res;

    logic [29:0] w_need;
    logic [29:0] w_need_up;
    logic [29:0] w_sum;
    logic [26:0] w_old_end;

    always_comb begin
        w_need    = {2'b0, r_want} + 30'(OVH_BYTES) + 30'(PAGE_BYTES);
        w_need_up = (w_need + 30'(PAGE_BYTES - 1)) & ~30'(PAGE_BYTES - 1);
        w_sum     = {3'b0, r_mapped} + w_need_up;
        w_old_end = {1'b0, r_lst.start} + 27'(OVH_BYTES) + {1'b0, r_lst.size};
    end

    always_comb begin
        n_st     = r_st;
        n_op     = r_op;
        n_size   = r_size;
        n_off    = r_off;
        n_want   = r_want;
        n_grown  = r_grown;
        n_count  = r_count;
        n_mapped = r_mapped;
        n_end    = r_end;
        n_bad    = r_bad;
        n_lst    = r_lst;
        n_ltok   = '0;
        n_vld    = 1'b0;
        n_pay    = r_pay;
        n_res    = r_res;
        case (r_st)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_size  = i_request_size;
                    n_off   = i_block_offset;
                    n_grown = 1'b0;
                    n_st    = S_CHK;
                end
            end
            S_CHK: begin
                n_want = ({1'b0, r_size} + 28'd7) & ~28'd7;
                n_pay  = '0;
                if (r_op == OPC_ALLOC) begin
                    if (r_size == '0) begin
                        n_res = ST_ZERO;
                        n_vld = 1'b1;
                        n_st  = S_IDLE;
                    end else begin
                        n_ltok.act  = 1'b1;
                        n_ltok.op   = TK_ALLOC;
                        n_ltok.md   = MD_SRCH;
                        n_ltok.want = ({1'b0, r_size} + 28'd7) & ~28'd7;
                        n_ltok.sok  = (r_count < CW'(MAX_BLOCKS));
                        n_st        = S_RUN;
                    end
                end else if (r_off == '0) begin
                    n_res = ST_NULL;
                    n_vld = 1'b1;
                    n_st  = S_IDLE;
                end else begin
                    n_ltok.act = 1'b1;
                    n_ltok.op  = TK_FREE;
                    n_ltok.md  = MD_SRCH;
                    n_ltok.off = r_off;
                    n_st       = S_RUN;
                end
            end
            S_RUN: begin
                if (i_tok.act) begin
                    case (i_tok.op)
                        TK_ALLOC: begin
                            if (i_tok.hit) begin
                                n_pay   = i_tok.pay;
                                n_res   = ST_OK;
                                n_count = r_count + CW'(i_tok.spl);
                                n_vld   = 1'b1;
                                n_st    = S_IDLE;
                            end else if (r_grown) begin
                                n_pay = '0;
                                n_res = ST_OOM;
                                n_vld = 1'b1;
                                n_st  = S_IDLE;
                            end else begin
                                n_lst = i_tok.lst;
                                n_st  = S_G1;
                            end
                        end
                        TK_FREE: begin
                            n_pay = '0;
                            if (i_tok.hit && !i_tok.dbl) begin
                                n_res   = ST_OK;
                                n_count = r_count - CW'(i_tok.mrg);
                            end else begin
                                n_res = i_tok.hit ? ST_DOUBLE : ST_NOT_START;
                                if (r_bad != '1) begin
                                    n_bad = r_bad + 32'd1;
                                end
                            end
                            n_vld = 1'b1;
                            n_st  = S_IDLE;
                        end
                        default: begin
                            n_grown     = 1'b1;
                            n_ltok.act  = 1'b1;
                            n_ltok.op   = TK_ALLOC;
                            n_ltok.md   = MD_SRCH;
                            n_ltok.want = r_want;
                            n_ltok.sok  = (r_count < CW'(MAX_BLOCKS));
                        end
                    endcase
                end
            end
            S_G1: begin
                if ({3'b0, r_mapped} + w_need > 30'(HEAP_LIMIT_BYTES)
                        || (!r_lst.free && r_count >= CW'(MAX_BLOCKS))) begin
                    n_pay = '0;
                    n_res = ST_OOM;
                    n_vld = 1'b1;
                    n_st  = S_IDLE;
                end else begin
                    n_end = (w_sum > 30'(HEAP_LIMIT_BYTES)) ? 27'(HEAP_LIMIT_BYTES)
                                                             : w_sum[26:0];
                    n_st  = S_G2;
                end
            end
            S_G2: begin
                n_ltok.act      = 1'b1;
                n_ltok.op       = TK_GROW;
                n_ltok.cry.v    = 1'b1;
                n_ltok.cry.free = 1'b1;
                if (r_lst.free) begin
                    n_ltok.md        = MD_EXT;
                    n_ltok.cry.start = r_lst.start;
                    n_ltok.cry.size  = 26'(r_end - w_old_end + {1'b0, r_lst.size});
                end else begin
                    n_ltok.md        = MD_APP;
                    n_ltok.cry.start = w_old_end[25:0];
                    n_ltok.cry.size  = 26'(r_end - w_old_end - 27'(OVH_BYTES));
                    n_count          = r_count + CW'(1);
                end
                n_mapped = r_end;
                n_st     = S_RUN;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_count  <= CW'(1);
            r_mapped <= 27'(INITIAL_BYTES);
            r_bad    <= '0;
            r_ltok   <= '0;
            r_vld    <= 1'b0;
            r_grown  <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_count  <= n_count;
            r_mapped <= n_mapped;
            r_bad    <= n_bad;
            r_ltok   <= n_ltok;
            r_vld    <= n_vld;
            r_grown  <= n_grown;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_size <= n_size;
        r_off  <= n_off;
        r_want <= n_want;
        r_end  <= n_end;
        r_lst  <= n_lst;
        r_pay  <= n_pay;
        r_res  <= n_res;
    end

    assign busy               = (r_st != S_IDLE);
    assign o_tok              = r_ltok;
    assign o_valid            = r_vld;
    assign o_payload_offset   = r_pay;
    assign o_status           = r_res;
    assign o_corruption_total = r_bad;

endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// Zero-size and null-free words answer from the check state, with no token pass.
// Alloc hit or free: one token pass over the cell row.
// Alloc miss with growth: three passes over the cell row.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous, active low; table holds one free block of the mapped heap.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
    parameter int MAX_BLOCKS       = ffha_pkg::C_MAX_BLOCKS,
    parameter int HEAP_LIMIT_BYTES = ffha_pkg::C_HEAP_LIMIT,
    parameter int PAGE_BYTES       = ffha_pkg::C_PAGE_BYTES,
    parameter int INITIAL_BYTES    = ffha_pkg::C_INIT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [26:0] i_request_size,
    input  logic [25:0] i_block_offset,
    output logic        o_valid,
    output logic [25:0] o_payload_offset,
    output logic [2:0]  o_status,
    output logic [31:0] o_corruption_total
);
    import ffha_pkg::*;

    `include "first_fit_heap_allocator_top_macros.svh"

    t_tok  w_tok  [0:MAX_BLOCKS];
    t_back w_back [0:MAX_BLOCKS];

    assign w_back[MAX_BLOCKS] = '0;

    ffha_ctrl #(
        .MAX_BLOCKS       (MAX_BLOCKS),
        .HEAP_LIMIT_BYTES (HEAP_LIMIT_BYTES),
        .PAGE_BYTES       (PAGE_BYTES),
        .INITIAL_BYTES    (INITIAL_BYTES)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_request_size     (i_request_size),
        .i_block_offset     (i_block_offset),
        .o_tok              (w_tok[0]),
        .i_tok              (w_tok[MAX_BLOCKS]),
        .o_valid            (o_valid),
        .o_payload_offset   (o_payload_offset),
        .o_status           (o_status),
        .o_corruption_total (o_corruption_total)
    );

    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        ffha_cell #(
            .P_FIRST (k == 0),
            .P_SIZE  (26'(INITIAL_BYTES - OVH_BYTES))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[k]),
            .i_back  (w_back[k+1]),
            .o_tok   (w_tok[k+1]),
            .o_back  (w_back[k])
        );
    end

    `FFHA_AST_NXT(a_accept_busy, start && !busy, busy)
    `FFHA_AST_IMP(a_fail_no_pay, o_valid && o_status != ST_OK, o_payload_offset == '0)
    `FFHA_AST_NXT(a_bad_mono, 1'b1, o_corruption_total >= $past(o_corruption_total))
    `FFHA_AST_IMP(a_idle_no_tok, !busy, !w_tok[0].act)

endmodule

@@ dv/first_fit_heap_allocator_top_test.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free words through the start/busy port and predicts each
// result with a cycle-free model of the block table. Directed corner words come
// first, then random phases that fill, drain and grow the heap.
// ----------------------------------------------------------------------------
class heap_scoreboard;
    typedef struct {
        logic [25:0]      pay;
        ffha_pkg::t_status st;
        logic [31:0]      tot;
    } heap_result_t;

    int unsigned  blk_start[ffha_pkg::C_MAX_BLOCKS];
    int unsigned  blk_size[ffha_pkg::C_MAX_BLOCKS];
    bit           blk_free[ffha_pkg::C_MAX_BLOCKS];
    int unsigned  blk_cnt;
    longint       mapped;
    int unsigned  bad_frees;
    heap_result_t pending[$];
    int           errors;
    int           status_seen[8];
    int           max_cnt;

    function new();
        for (int k = 0; k < ffha_pkg::C_MAX_BLOCKS; k++) begin
            blk_start[k] = 0;
            blk_size[k]  = 0;
            blk_free[k]  = 0;
        end
        blk_size[0] = ffha_pkg::C_INIT_BYTES - ffha_pkg::OVH_BYTES;
        blk_free[0] = 1;
        blk_cnt     = 1;
        mapped      = ffha_pkg::C_INIT_BYTES;
        bad_frees   = 0;
        errors      = 0;
        max_cnt     = 1;
    endfunction

    function bit first_fit(longint want, output longint pay);
        pay = 0;
        for (int k = 0; k < blk_cnt; k++) begin
            if (blk_free[k] && longint'(blk_size[k]) >= want) begin
                if (longint'(blk_size[k]) >= want + ffha_pkg::SPLIT_MIN &&
                    blk_cnt < ffha_pkg::C_MAX_BLOCKS) begin
                    for (int j = blk_cnt; j > k + 1; j--) begin
                        blk_start[j] = blk_start[j-1];
                        blk_size[j]  = blk_size[j-1];
                        blk_free[j]  = blk_free[j-1];
                    end
                    blk_start[k+1] = blk_start[k] + ffha_pkg::OVH_BYTES + int'(want);
                    blk_size[k+1]  = blk_size[k] - int'(want) - ffha_pkg::OVH_BYTES;
                    blk_free[k+1]  = 1;
                    blk_cnt++;
                    blk_size[k] = int'(want);
                end
                blk_free[k] = 0;
                pay = longint'(blk_start[k]) + ffha_pkg::HDR_BYTES;
                return 1;
            end
        end
        return 0;
    endfunction

    function bit grow(longint want);
        longint need, pages, new_end, old_end;
        int unsigned last;
        need = want + ffha_pkg::OVH_BYTES + ffha_pkg::C_PAGE_BYTES;
        last = blk_cnt - 1;
        if (mapped + need > ffha_pkg::C_HEAP_LIMIT) return 0;
        if (!blk_free[last] && blk_cnt >= ffha_pkg::C_MAX_BLOCKS) return 0;
        pages   = (need + ffha_pkg::C_PAGE_BYTES - 1) / ffha_pkg::C_PAGE_BYTES;
        new_end = mapped + pages * ffha_pkg::C_PAGE_BYTES;
        if (new_end > ffha_pkg::C_HEAP_LIMIT) new_end = ffha_pkg::C_HEAP_LIMIT;
        old_end = longint'(blk_start[last]) + ffha_pkg::OVH_BYTES + blk_size[last];
        if (blk_free[last]) begin
            blk_size[last] = int'(new_end - old_end) + blk_size[last];
        end else begin
            blk_start[blk_cnt] = int'(old_end);
            blk_size[blk_cnt]  = int'(new_end - old_end - ffha_pkg::OVH_BYTES);
            blk_free[blk_cnt]  = 1;
            blk_cnt++;
        end
        mapped = new_end;
        return 1;
    endfunction

    function void note_word(logic op, logic [26:0] size, logic [25:0] off);
        heap_result_t r;
        longint want, pay;
        int idx;
        pay  = 0;
        r.st = ffha_pkg::ST_OK;
        if (op == ffha_pkg::OPC_ALLOC) begin
            if (size == 0) begin
                r.st = ffha_pkg::ST_ZERO;
            end else begin
                want = (longint'(size) + 7) & ~longint'(7);
                if (!first_fit(want, pay)) begin
                    if (!grow(want) || !first_fit(want, pay)) begin
                        pay  = 0;
                        r.st = ffha_pkg::ST_OOM;
                    end
                end
            end
        end else if (off == 0) begin
            r.st = ffha_pkg::ST_NULL;
        end else begin
            idx = -1;
            for (int k = 0; k < blk_cnt; k++)
                if (idx < 0 && longint'(blk_start[k]) + ffha_pkg::HDR_BYTES == off) idx = k;
            if (idx < 0 || blk_free[idx]) begin
                r.st = (idx < 0) ? ffha_pkg::ST_NOT_START : ffha_pkg::ST_DOUBLE;
                if (bad_frees != 32'hFFFF_FFFF) bad_frees++;
            end else begin
                blk_free[idx] = 1;
                if (idx + 1 < blk_cnt && blk_free[idx+1]) begin
                    blk_size[idx] += ffha_pkg::OVH_BYTES + blk_size[idx+1];
                    for (int j = idx + 1; j + 1 < blk_cnt; j++) begin
                        blk_start[j] = blk_start[j+1];
                        blk_size[j]  = blk_size[j+1];
                        blk_free[j]  = blk_free[j+1];
                    end
                    blk_cnt--;
                end
            end
        end
        if (blk_cnt > max_cnt) max_cnt = blk_cnt;
        r.pay = pay[25:0];
        r.tot = bad_frees;
        status_seen[r.st]++;
        pending.push_back(r);
    endfunction

    function void check_result(logic [25:0] pay, logic [2:0] st, logic [31:0] tot);
        heap_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result pay=%0d status=%0d total=%0d",
                     $time, pay, st, tot);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (pay !== e.pay) begin
            $display("%0t: payload_offset expected %0d actual %0d", $time, e.pay, pay);
            errors++;
        end
        if (st !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            errors++;
        end
        if (tot !== e.tot) begin
            $display("%0t: corruption_total expected %0d actual %0d", $time, e.tot, tot);
            errors++;
        end
    endfunction

    function logic [25:0] pick_block(bit want_used);
        int unsigned cand[$];
        for (int k = 0; k < blk_cnt; k++)
            if (!want_used || !blk_free[k]) cand.push_back(k);
        if (cand.size() == 0) return 26'(blk_start[0] + ffha_pkg::HDR_BYTES);
        return 26'(blk_start[cand[$urandom_range(cand.size() - 1)]] + ffha_pkg::HDR_BYTES);
    endfunction
endclass

module first_fit_heap_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = ffha_pkg::OPC_ALLOC;
    logic [26:0] i_request_size = '0;
    logic [25:0] i_block_offset = '0;
    logic        o_valid;
    logic [25:0] o_payload_offset;
    logic [2:0]  o_status;
    logic [31:0] o_corruption_total;

    heap_scoreboard heap_sb = new();
    int stall_cycles = 0;

    first_fit_heap_allocator_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_block_offset    (i_block_offset),
        .o_valid           (o_valid),
        .o_payload_offset  (o_payload_offset),
        .o_status          (o_status),
        .o_corruption_total(o_corruption_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            heap_sb.check_result(o_payload_offset, o_status, o_corruption_total);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (i_rst_n) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 5000) begin
                $display("watchdog expired at %0t", $time);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(logic op, logic [26:0] size, logic [25:0] off);
        start          <= 1'b1;
        i_opcode       <= op;
        i_request_size <= size;
        i_block_offset <= off;
        do @(posedge i_clk); while (busy);
        heap_sb.note_word(op, size, off);
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic alloc(logic [26:0] size);
        send_word(ffha_pkg::OPC_ALLOC, size, 26'($urandom));
    endtask

    task automatic release_at(logic [25:0] off);
        send_word(ffha_pkg::OPC_FREE, 27'($urandom), off);
    endtask

    task automatic random_word(int phase);
        int r;
        int alloc_pct;
        logic [26:0] size;
        logic [25:0] off;
        alloc_pct = (phase == 0) ? 60 : (phase == 1) ? 95 : (phase == 2) ? 25 : 55;
        if ($urandom_range(99) < alloc_pct) begin
            r = $urandom_range(99);
            if (phase == 1 || r < 80)  size = 27'($urandom_range(1, 128));
            else if (r < 92)           size = 27'($urandom_range(129, 16384));
            else if (r < 98)           size = 27'($urandom_range(16385, 1 << 20));
            else                       size = 27'($urandom);
            if (size > 27'd67108864) size = 27'($urandom_range(0, 67108864));
            alloc(size);
        end else begin
            r = $urandom_range(99);
            if (r < 70)      off = heap_sb.pick_block(1);
            else if (r < 80) off = heap_sb.pick_block(0);
            else if (r < 88) off = '0;
            else if (r < 94) off = heap_sb.pick_block(0) + 26'($urandom_range(1, 64));
            else             off = 26'($urandom);
            release_at(off);
        end
    endtask

    initial begin
        logic [25:0] p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        alloc(27'd0);
        alloc(27'd1);
        alloc(27'd8);
        alloc(27'd67108864);
        alloc(27'h3FF_FFFF);
        alloc(27'd40);
        release_at('0);
        release_at(26'd1);
        release_at(26'h3FF_FFFF);
        p = heap_sb.pick_block(1);
        release_at(p);
        release_at(p);
        alloc(27'd16000);
        alloc(27'd20000);
        alloc(27'd5555555);
        release_at(heap_sb.pick_block(1));
        release_at(heap_sb.pick_block(1));
        alloc(27'd7);
        alloc(27'd300);
        release_at(26'd33);

        for (int k = 0; k < 1150; k++) begin
            if (k == 600) begin
                start <= 1'b0;
                wait (heap_sb.pending.size() == 0);
                @(posedge i_clk);
            end
            if ((k < 400 || k > 700) && $urandom_range(99) < 14)
                hold_off($urandom_range(1, 4));
            random_word((k / 150) % 4);
        end
        start <= 1'b0;

        wait (heap_sb.pending.size() == 0);
        repeat (50) @(posedge i_clk);
        if (heap_sb.pending.size() != 0) begin
            $display("%0d results never arrived", heap_sb.pending.size());
            heap_sb.errors++;
        end
        $display("covered: ok %0d, zero %0d, oom %0d, null %0d, not-start %0d, double %0d",
                 heap_sb.status_seen[0], heap_sb.status_seen[1], heap_sb.status_seen[2],
                 heap_sb.status_seen[3], heap_sb.status_seen[4], heap_sb.status_seen[5]);
        $display("peak table blocks %0d, mapped bytes %0d, mismatches %0d",
                 heap_sb.max_cnt, heap_sb.mapped, heap_sb.errors);
        if (heap_sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_cell.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_top.sv
dv/first_fit_heap_allocator_top_test.sv
